// ===== hw/rtl/rts_pkg.sv =====
// Shared types and constants for the rotating thermal supervisor.
package rts_pkg;

   localparam int unsigned SENSOR_COUNT = 3;
   localparam int unsigned TEMP_W       = 8;
   localparam int unsigned SINCE_W      = 16;
   localparam int unsigned AGE_W        = 20;
   localparam int unsigned ROT_W        = 2;
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 20;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned REQ_USER_W   = 2;
   localparam int unsigned RSP_DATA_W   = 32;

   localparam logic [TEMP_W-1:0]        NO_READING   = 8'h80;
   localparam logic signed [TEMP_W-1:0] SUSPECT_BAND = 8'sd5;
   localparam logic [SINCE_W-1:0]       SINCE_MAX    = 16'hFFFF;
   localparam logic [SENSOR_COUNT-1:0]  ALL_PRESENT  = 3'b111;
   localparam logic [ROT_W-1:0]         LAST_SENSOR  = 2'd2;

   // Request kinds.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_PRESENT_MASK    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAIN_LIMIT      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MOTOR_LIMIT     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_READ_INTERVAL   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FAILURE_TIMEOUT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_PROTECTION_ON   = 3'd5;

   typedef struct packed {
      logic [SENSOR_COUNT-1:0] present_mask;
      logic [TEMP_W-1:0]       main_limit;
      logic [TEMP_W-1:0]       motor_limit;
      logic [SINCE_W-1:0]      read_interval;
      logic [AGE_W-1:0]        failure_timeout;
      logic                    protection_on;
   } cfg_type;

   typedef struct packed {
      logic [SINCE_W-1:0]                   since_read;
      logic [ROT_W-1:0]                     rotation;
      logic [SENSOR_COUNT-1:0][TEMP_W-1:0]  temps;
      logic [SENSOR_COUNT-1:0][AGE_W-1:0]   ages;
   } state_type;

   typedef struct packed {
      logic              shutdown_request;
      logic              sensor_failed;
      logic              motor_hot;
      logic              main_hot;
      logic [TEMP_W-1:0] left_temp;
      logic [TEMP_W-1:0] right_temp;
      logic [TEMP_W-1:0] main_temp;
      logic [ROT_W-1:0]  due_sensor;
      logic              read_due;
   } result_type;

endpackage

// ===== hw/rtl/rotating_thermal_supervisor.sv =====
// Top level of the rotating thermal supervisor.
// The response is registered and appears on rsp in the cycle after its request is accepted.
// Throughput: one request per cycle; the response register frees as it is taken,
// so req_tready stays high while rsp_tready is high.
// Reset empties the response register, clears the counters and rotation, marks every
// temperature as no reading and loads the configuration defaults.
module rotating_thermal_supervisor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [rts_pkg::REQ_DATA_W-1:0]        req_tdata,  // [7:0] reading
   input  logic [rts_pkg::REQ_USER_W-1:0]        req_tuser,  // [0] opcode, [1] read_ok
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] read_due, [2:1] due_sensor, [10:3] main_temp, [18:11] right_temp,
   // [26:19] left_temp, [27] main_hot, [28] motor_hot, [29] sensor_failed,
   // [30] shutdown_request, [31] zero
   output logic [rts_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                  csr_we,
   input  logic [rts_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [rts_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   rts_pkg::cfg_type    cfg_ff;
   rts_pkg::state_type  state_in;
   rts_pkg::result_type result;
   rts_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;
   logic                accept;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.present_mask    <= '0;
         cfg_ff.main_limit      <= 8'd85;
         cfg_ff.motor_limit     <= 8'd85;
         cfg_ff.read_interval   <= 16'd1000;
         cfg_ff.failure_timeout <= 20'd10000;
         cfg_ff.protection_on   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            rts_pkg::CSR_PRESENT_MASK: begin
               cfg_ff.present_mask <= csr_wdata[rts_pkg::SENSOR_COUNT-1:0];
            end
            rts_pkg::CSR_MAIN_LIMIT: begin
               cfg_ff.main_limit <= csr_wdata[rts_pkg::TEMP_W-1:0];
            end
            rts_pkg::CSR_MOTOR_LIMIT: begin
               cfg_ff.motor_limit <= csr_wdata[rts_pkg::TEMP_W-1:0];
            end
            rts_pkg::CSR_READ_INTERVAL: begin
               cfg_ff.read_interval <= csr_wdata[rts_pkg::SINCE_W-1:0];
            end
            rts_pkg::CSR_FAILURE_TIMEOUT: begin
               cfg_ff.failure_timeout <= csr_wdata[rts_pkg::AGE_W-1:0];
            end
            rts_pkg::CSR_PROTECTION_ON: begin
               cfg_ff.protection_on <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   rts_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .opcode   (req_tuser[0]),
      .read_ok  (req_tuser[1]),
      .reading  (req_tdata[rts_pkg::TEMP_W-1:0]),
      .cfg      (cfg_ff),
      .state_in (state_in)
   );

   rts_status u_status (
      .state_in (state_in),
      .cfg      (cfg_ff),
      .result   (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

endmodule

// ===== hw/rtl/rts_core.sv =====
// Supervisor state registers and their next-state logic for one request.
module rts_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               opcode,
   input  logic                               read_ok,
   input  logic [rts_pkg::TEMP_W-1:0]         reading,
   input  rts_pkg::cfg_type                   cfg,
   output rts_pkg::state_type                 state_in
);

   rts_pkg::state_type state_ff;

   logic                               due;
   logic signed [rts_pkg::TEMP_W-1:0]  prev;
   logic                               known;

   always_comb begin
      state_in = state_ff;
      due      = state_ff.since_read >= cfg.read_interval;
      prev     = '0;
      known    = 1'b0;
      if (opcode == rts_pkg::OP_TICK) begin
         if (state_ff.since_read < rts_pkg::SINCE_MAX) begin
            state_in.since_read = state_ff.since_read + 1'b1;
         end
         for (int i = 0; i < rts_pkg::SENSOR_COUNT; i++) begin
            if (state_ff.ages[i] < cfg.failure_timeout) begin
               state_in.ages[i] = state_ff.ages[i] + 1'b1;
            end
         end
      end else if (due) begin
         for (int i = 0; i < rts_pkg::SENSOR_COUNT; i++) begin
            prev  = $signed(state_ff.temps[i]);
            known = state_ff.temps[i] != rts_pkg::NO_READING;
            // A reading of exactly zero is distrusted when the last known
            // value lay outside the small band around zero.
            if (state_ff.rotation == i[rts_pkg::ROT_W-1:0] && cfg.present_mask[i] &&
                read_ok && (reading != '0 || !known ||
                (prev >= -rts_pkg::SUSPECT_BAND && prev <= rts_pkg::SUSPECT_BAND))) begin
               state_in.temps[i] = reading;
               state_in.ages[i]  = '0;
            end
         end
         state_in.since_read = '0;
         state_in.rotation   = (state_ff.rotation >= rts_pkg::LAST_SENSOR) ? '0 :
                               state_ff.rotation + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.since_read <= '0;
         state_ff.rotation   <= '0;
         for (int i = 0; i < rts_pkg::SENSOR_COUNT; i++) begin
            state_ff.temps[i] <= rts_pkg::NO_READING;
            state_ff.ages[i]  <= '0;
         end
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/rts_status.sv =====
// Overheat, failure and shutdown flags, with the due and temperature fields, derived from the updated state.
module rts_status (
   input  rts_pkg::state_type  state_in,
   input  rts_pkg::cfg_type    cfg,
   output rts_pkg::result_type result
);

   logic [rts_pkg::SENSOR_COUNT-1:0] hot;
   logic [rts_pkg::SENSOR_COUNT-1:0] stale;
   logic [rts_pkg::TEMP_W-1:0]       limit;

   always_comb begin
      hot   = '0;
      stale = '0;
      limit = '0;
      for (int i = 0; i < rts_pkg::SENSOR_COUNT; i++) begin
         limit    = (i == 0) ? cfg.main_limit : cfg.motor_limit;
         hot[i]   = cfg.present_mask[i] && state_in.temps[i] != rts_pkg::NO_READING &&
                    $signed(state_in.temps[i]) >= $signed(limit);
         stale[i] = state_in.ages[i] >= cfg.failure_timeout;
      end
   end

   always_comb begin
      result.read_due         = state_in.since_read >= cfg.read_interval;
      result.due_sensor       = state_in.rotation;
      result.main_temp        = state_in.temps[0];
      result.right_temp       = state_in.temps[1];
      result.left_temp        = state_in.temps[2];
      result.main_hot         = hot[0];
      result.motor_hot        = hot[1] || hot[2];
      result.sensor_failed    = (cfg.present_mask != rts_pkg::ALL_PRESENT) || (|stale);
      result.shutdown_request = cfg.protection_on &&
                                (result.main_hot || result.motor_hot || result.sensor_failed);
   end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the rotating thermal supervisor, with a status predictor.
`timescale 1ns / 1ps

module tb_top;
   import rts_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASE_ITEMS   = 150;
   localparam int RANDOM_PHASES = 9;
   localparam int HOLD_CYCLES   = 300;
   localparam int TICK_RUN      = 20;

   // Mirrors the supervisor's counters, temperatures and registers, and keeps
   // the status words that accepted requests still owe.
   class supervisor_mirror;
      cfg_type     cfg;
      state_type   st;
      result_type  owed_status[$];
      int unsigned mismatches;
      int unsigned stored_reads;
      int unsigned suspect_zeros;
      int unsigned skipped_slots;
      int unsigned ignored_reads;
      int unsigned statuses_seen;

      function new();
         cfg.present_mask    = '0;
         cfg.main_limit      = 8'd85;
         cfg.motor_limit     = 8'd85;
         cfg.read_interval   = 16'd1000;
         cfg.failure_timeout = 20'd10000;
         cfg.protection_on   = 1'b1;
         st.since_read       = '0;
         st.rotation         = '0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            st.temps[i] = NO_READING;
            st.ages[i]  = '0;
         end
         mismatches    = 0;
         stored_reads  = 0;
         suspect_zeros = 0;
         skipped_slots = 0;
         ignored_reads = 0;
         statuses_seen = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
         case (addr)
            CSR_PRESENT_MASK:    cfg.present_mask    = value[SENSOR_COUNT-1:0];
            CSR_MAIN_LIMIT:      cfg.main_limit      = value[TEMP_W-1:0];
            CSR_MOTOR_LIMIT:     cfg.motor_limit     = value[TEMP_W-1:0];
            CSR_READ_INTERVAL:   cfg.read_interval   = value[SINCE_W-1:0];
            CSR_FAILURE_TIMEOUT: cfg.failure_timeout = value[AGE_W-1:0];
            CSR_PROTECTION_ON:   cfg.protection_on   = value[0];
            default: ;
         endcase
      endfunction

      function bit slot_due();
         return st.since_read >= cfg.read_interval;
      endfunction

      function bit is_hot(int idx, logic [TEMP_W-1:0] limit);
         return cfg.present_mask[idx] && st.temps[idx] != NO_READING
                && $signed(st.temps[idx]) >= $signed(limit);
      endfunction

      // Applies one request and queues the status it must produce. Returns 1
      // when the request did something, that is, a tick or a served slot.
      function bit apply_request(logic opcode, logic read_ok, logic [TEMP_W-1:0] reading);
         result_type r;
         int         s;
         int         prev;
         int         mag;
         bit         due;
         bit         failed;
         due = slot_due();
         if (opcode == OP_TICK) begin
            if (st.since_read != SINCE_MAX)
               st.since_read = st.since_read + 1'b1;
            for (int i = 0; i < SENSOR_COUNT; i++)
               if (st.ages[i] < cfg.failure_timeout)
                  st.ages[i] = st.ages[i] + 1'b1;
         end else if (due) begin
            s = st.rotation;
            if (s < SENSOR_COUNT && cfg.present_mask[s] && read_ok) begin
               prev = $signed(st.temps[s]);
               mag  = (prev < 0) ? -prev : prev;
               // A zero is distrusted when the last known value was well away from it.
               if (reading != '0 || st.temps[s] == NO_READING || mag <= SUSPECT_BAND) begin
                  st.temps[s] = reading;
                  st.ages[s]  = '0;
                  stored_reads++;
               end else begin
                  suspect_zeros++;
               end
            end else begin
               skipped_slots++;
            end
            st.since_read = '0;
            st.rotation   = (st.rotation >= LAST_SENSOR) ? '0 : st.rotation + 1'b1;
         end else begin
            ignored_reads++;
         end

         r.read_due   = slot_due();
         r.due_sensor = st.rotation;
         r.main_temp  = st.temps[0];
         r.right_temp = st.temps[1];
         r.left_temp  = st.temps[2];
         r.main_hot   = is_hot(0, cfg.main_limit);
         r.motor_hot  = is_hot(1, cfg.motor_limit) || is_hot(2, cfg.motor_limit);
         failed = cfg.present_mask != ALL_PRESENT;
         for (int i = 0; i < SENSOR_COUNT; i++)
            if (st.ages[i] >= cfg.failure_timeout)
               failed = 1'b1;
         r.sensor_failed    = failed;
         r.shutdown_request = cfg.protection_on && (r.main_hot || r.motor_hot || failed);
         owed_status.push_back(r);
         return opcode == OP_TICK || due;
      endfunction

      function void compare_field(string name, int expv, int gotv);
         if (expv != gotv) begin
            $error("%s: expected %0d, got %0d", name, expv, gotv);
            mismatches++;
         end
      endfunction

      function void check_status(logic [RSP_DATA_W-1:0] data);
         result_type exp;
         result_type got;
         if (owed_status.size() == 0) begin
            $error("status word %h arrived with no request outstanding", data);
            mismatches++;
            return;
         end
         exp = owed_status.pop_front();
         got = data[$bits(result_type)-1:0];
         statuses_seen++;
         compare_field("read_due", exp.read_due, got.read_due);
         compare_field("due_sensor", exp.due_sensor, got.due_sensor);
         compare_field("main_temp", $signed(exp.main_temp), $signed(got.main_temp));
         compare_field("right_temp", $signed(exp.right_temp), $signed(got.right_temp));
         compare_field("left_temp", $signed(exp.left_temp), $signed(got.left_temp));
         compare_field("main_hot", exp.main_hot, got.main_hot);
         compare_field("motor_hot", exp.motor_hot, got.motor_hot);
         compare_field("sensor_failed", exp.sensor_failed, got.sensor_failed);
         compare_field("shutdown_request", exp.shutdown_request, got.shutdown_request);
         compare_field("spare bit", 0, data[RSP_DATA_W-1]);
      endfunction
   endclass

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   supervisor_mirror mirror;
   bit               idling_on    = 1'b1;
   bit               hold_trigger = 1'b0;
   bit               hold_taken   = 1'b0;
   int               hold_left    = 0;
   int unsigned      cycle_count  = 0;
   int unsigned      requests     = 0;
   int unsigned      useful_items = 0;
   int unsigned      phases_run   = 0;

   rotating_thermal_supervisor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Status receiver: checks each accepted status word and chooses the next
   // ready value, including one long hold-off that backs up the request side.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mirror.check_status(rsp_tdata);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_trigger && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idling_on || $urandom_range(99) >= 33;
      end
   end

   task automatic send_request(logic opcode, logic read_ok, logic [TEMP_W-1:0] reading);
      if (idling_on && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {read_ok, opcode};
      req_tdata  <= reading;
      do @(posedge clock); while (!req_tready);
      requests++;
      if (mirror.apply_request(opcode, read_ok, reading))
         useful_items++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (mirror.owed_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Registers are only written once every owed status word has come back.
   task automatic configure(int mask, int main_lim, int motor_lim, int interval,
                            int timeout, int prot);
      logic [CSR_ADDR_W-1:0] addrs [6] = '{CSR_PRESENT_MASK, CSR_MAIN_LIMIT, CSR_MOTOR_LIMIT,
                                          CSR_READ_INTERVAL, CSR_FAILURE_TIMEOUT,
                                          CSR_PROTECTION_ON};
      int                    values [6] = '{mask, main_lim, motor_lim, interval, timeout, prot};
      wait_drained();
      foreach (addrs[i]) begin
         csr_we    <= 1'b1;
         csr_addr  <= addrs[i];
         csr_wdata <= CSR_DATA_W'(values[i]);
         @(posedge clock);
         mirror.write_reg(addrs[i], CSR_DATA_W'(values[i]));
      end
      csr_we <= 1'b0;
      phases_run++;
   endtask

   function automatic logic [TEMP_W-1:0] pick_reading();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25)
         return 8'h00;
      if (roll < 33)
         return NO_READING;
      if (roll < 45)
         return $urandom_range(1) ? 8'($urandom_range(6, 4)) : -8'($urandom_range(6, 4));
      if (roll < 55)
         return $urandom_range(1) ? 8'h7F : 8'h81;
      return 8'($urandom);
   endfunction

   function automatic int pick_limit();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return -128;
      if (roll < 20)
         return 127;
      if (roll < 30)
         return -127;
      return int'($urandom_range(60)) - 20;
   endfunction

   task automatic random_phase(int phase_no);
      int roll;
      int timeout;
      int target;
      bit held;
      bit paused;
      held   = 1'b0;
      paused = 1'b0;
      roll   = $urandom_range(99);
      if (roll < 5)
         timeout = 0;
      else if (roll < 10)
         timeout = 1048575;
      else
         timeout = $urandom_range(40, 1);
      configure(($urandom_range(99) < 65) ? 7 : $urandom_range(7), pick_limit(), pick_limit(),
                ($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1), timeout,
                ($urandom_range(99) < 70) ? 1 : 0);
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) begin
         if (phase_no == 2 && !held && useful_items > target - PHASE_ITEMS / 2) begin
            hold_trigger <= 1'b1;
            held = 1'b1;
         end
         if (phase_no == 5 && !paused && useful_items > target - PHASE_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         roll = $urandom_range(99);
         if (roll < 85) begin
            // A proper slot: tick until due, sometimes linger, then report the read.
            while (!mirror.slot_due())
               send_request(OP_TICK, 1'($urandom_range(1)), pick_reading());
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(4, 1))
                  send_request(OP_TICK, 1'($urandom_range(1)), pick_reading());
            send_request(OP_READ, $urandom_range(99) < 90, pick_reading());
         end else if (roll < 90) begin
            // A long silence lets the sensor ages run into the timeout.
            repeat ($urandom_range(50, 20))
               send_request(OP_TICK, 1'($urandom_range(1)), pick_reading());
         end else begin
            send_request(1'($urandom_range(1)), 1'($urandom_range(1)), pick_reading());
         end
      end
   endtask

   initial begin
      int ok_seq [15] = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 1, 1};
      int rd_seq [15] = '{127, -127, 0, 0, 0, -5, 55, 5, 0, -128, 0, 6, 0, -6, 0};
      mirror = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: nothing present, and a read before any slot is due is ignored.
      send_request(OP_TICK, 1'b1, 8'h7F);
      send_request(OP_READ, 1'b1, 8'd50);

      // With a zero interval every read serves a slot, so the rotation walks
      // through stores, suspect zeros, failed reads and the no-reading code.
      configure(7, 20, 10, 0, 3, 1);
      foreach (ok_seq[i])
         send_request(OP_READ, 1'(ok_seq[i]), 8'(rd_seq[i]));
      repeat (4) send_request(OP_TICK, 1'b0, 8'h00);

      // Right sensor absent: its slot is consumed without storing.
      configure(5, -128, 127, 2, 10, 0);
      send_request(OP_READ, 1'b1, 8'd30);
      repeat (2) send_request(OP_TICK, 1'b0, 8'h00);
      send_request(OP_READ, 1'b1, 8'd30);
      repeat (2) send_request(OP_TICK, 1'b0, 8'h00);
      send_request(OP_READ, 1'b1, 8'd77);

      // Timeout dropped below the current ages, then to zero.
      configure(7, 127, -127, 1, 1, 1);
      send_request(OP_TICK, 1'b0, 8'h00);
      configure(7, 0, 0, 1, 0, 1);
      send_request(OP_TICK, 1'b0, 8'h00);
      send_request(OP_READ, 1'b1, 8'h00);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idling_on <= (p != 0);
         random_phase(p);
      end

      // Widest interval and timeout: a short tick run leaves no slot due,
      // so the reads that follow are ignored.
      configure(7, 127, -127, 65535, 1048575, 1);
      idling_on <= 1'b0;
      repeat (TICK_RUN) send_request(OP_TICK, 1'($urandom_range(1)), 8'($urandom));
      send_request(OP_READ, 1'b1, 8'd42);
      send_request(OP_READ, 1'b1, 8'd43);

      wait_drained();
      repeat (3) @(posedge clock);
      if (mirror.owed_status.size() != 0)
         $error("%0d status words never arrived", mirror.owed_status.size());
      $display("%0d requests sent: %0d readings stored, %0d suspect zeros dropped, %0d slots consumed",
               requests, mirror.stored_reads, mirror.suspect_zeros, mirror.skipped_slots);
      $display("%0d reads with no slot due, %0d register settings, %0d status words checked",
               mirror.ignored_reads, phases_run, mirror.statuses_seen);
      if (mirror.mismatches == 0 && mirror.owed_status.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== rotating_thermal_supervisor.f =====
hw/rtl/rts_pkg.sv
hw/rtl/rts_core.sv
hw/rtl/rts_status.sv
hw/rtl/rotating_thermal_supervisor.sv
bench/tb_top.sv
